// File: hw/rtl/c5rgb_pkg.sv
`default_nettype none

package c5rgb_pkg;

  // Filter geometry
  localparam int WIN_ROWS   = 5;
  localparam int WIN_COLS   = 13;
  localparam int STORE_ROWS = 4;
  localparam int TAPS       = 25;
  localparam int TAP_COLS   = 5;
  localparam int TAP_STEP   = 3;
  localparam int FIRST_COL  = WIN_COLS - 1;
  localparam int PIX_MAX    = 255;

  // Configuration port
  localparam int CFG_AW     = 6;
  localparam int CFG_DW     = 64;
  localparam int COEF_PACKS = 6;
  localparam int COEF_W     = 16;
  localparam int OW_W       = 11;
  localparam int SPAN_W     = 13;
  localparam logic [OW_W-1:0] OUT_WIDTH_RST = 11'd640;

  typedef enum logic [2:0] {
    REG_COEF0     = 3'd0,
    REG_COEF1     = 3'd1,
    REG_COEF2     = 3'd2,
    REG_COEF3     = 3'd3,
    REG_COEF4     = 3'd4,
    REG_COEF5     = 3'd5,
    REG_COEF_LAST = 3'd6,
    REG_OUT_WIDTH = 3'd7
  } reg_idx_t;

  // Flags that travel with a word from the address stage to the read-data stage
  typedef struct packed {
    logic emit;
    logic row_end;
    logic in_range;
  } s1_tag_t;

endpackage

`default_nettype wire

// File: hw/rtl/c5rgb_ram.sv
`default_nettype none

module c5rgb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: hw/rtl/conv5x5_rgb_clamped.sv
`default_nettype none

// 5x5 convolution over an interleaved RGB byte stream, clamped to 0..255.
// Input channel (in_valid/in_ready): one source byte per word in raster
// order, with in_row_end on the last byte of a row and in_frame_start on the
// first byte of a frame. Taps are three bytes apart, so each channel is
// filtered with bytes of its own kind.
// Output channel (out_valid/out_ready): one filtered byte per word, for source
// byte columns 12 .. 12+3*out_width-1 of every row once four rows have passed;
// out_row_end marks the last byte of an output row.
// Configuration: APB-style port, 64-bit data, register i at byte address 8*i
// (six coefficient packs, the last coefficient, out_width). Write only while
// the stream is idle.
// After its input word is accepted, a result passes through the row store read,
// window shift, products, row sums and clamp/output register, in that order.
// Throughput: one word per cycle while out_ready stays high; the row store is
// a single RAM word of four bytes per column, read at one port and written back
// at the other each cycle, with a forward path for back-to-back same-column words.
// Reset: counters and configuration return to defaults; the row store is not
// cleared and needs no clearing pass. When the receiver stalls, the pipeline
// fills and in_ready drops only once every stage holds a word.
module conv5x5_rgb_clamped #(
  parameter int MAX_ROW_BYTES = 4096
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input channel
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [7:0]                       in_pixel_byte,
  input  wire logic                             in_row_end,
  input  wire logic                             in_frame_start,
  // output channel
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [7:0]                       out_byte,
  output logic                                  out_row_end,
  // configuration port
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [c5rgb_pkg::CFG_AW-1:0]     cfg_paddr,
  input  wire logic [c5rgb_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic      [c5rgb_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int CW = $clog2(MAX_ROW_BYTES + 1);   // column counter, holds the max
  localparam int AW = $clog2(MAX_ROW_BYTES);       // row store address
  localparam int SW = (CW > c5rgb_pkg::SPAN_W) ? CW : c5rgb_pkg::SPAN_W;
  localparam int RW = 8 * c5rgb_pkg::STORE_ROWS;   // one RAM word = one column

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [c5rgb_pkg::CFG_DW-1:0] coef_pack_r [c5rgb_pkg::COEF_PACKS];
  logic [c5rgb_pkg::COEF_W-1:0] coef_last_r;
  logic [c5rgb_pkg::OW_W-1:0]   out_width_r;
  c5rgb_pkg::reg_idx_t          cfg_idx;
  logic                         cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = c5rgb_pkg::reg_idx_t'(cfg_paddr[c5rgb_pkg::CFG_AW-1:3]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < c5rgb_pkg::COEF_PACKS; p++) begin
        coef_pack_r[p] <= '0;
      end
      coef_last_r <= '0;
      out_width_r <= c5rgb_pkg::OUT_WIDTH_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx) inside
        c5rgb_pkg::REG_COEF0, c5rgb_pkg::REG_COEF1, c5rgb_pkg::REG_COEF2,
        c5rgb_pkg::REG_COEF3, c5rgb_pkg::REG_COEF4, c5rgb_pkg::REG_COEF5: begin
          coef_pack_r[cfg_idx] <= cfg_pwdata;
        end
        c5rgb_pkg::REG_COEF_LAST: begin
          coef_last_r <= cfg_pwdata[c5rgb_pkg::COEF_W-1:0];
        end
        c5rgb_pkg::REG_OUT_WIDTH: begin
          out_width_r <= cfg_pwdata[c5rgb_pkg::OW_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx) inside
      c5rgb_pkg::REG_COEF0, c5rgb_pkg::REG_COEF1, c5rgb_pkg::REG_COEF2,
      c5rgb_pkg::REG_COEF3, c5rgb_pkg::REG_COEF4, c5rgb_pkg::REG_COEF5: begin
        cfg_prdata = coef_pack_r[cfg_idx];
      end
      c5rgb_pkg::REG_COEF_LAST: begin
        cfg_prdata = c5rgb_pkg::CFG_DW'(coef_last_r);
      end
      c5rgb_pkg::REG_OUT_WIDTH: begin
        cfg_prdata = c5rgb_pkg::CFG_DW'(out_width_r);
      end
      default: begin
        cfg_prdata = '0;
      end
    endcase
  end

  // Unpack the 25 coefficients, index 5*row+col
  logic [c5rgb_pkg::COEF_W-1:0] coef [c5rgb_pkg::TAPS];

  always_comb begin
    for (int k = 0; k < c5rgb_pkg::TAPS - 1; k++) begin
      coef[k] = coef_pack_r[k / 4][c5rgb_pkg::COEF_W * (k % 4) +: c5rgb_pkg::COEF_W];
    end
    coef[c5rgb_pkg::TAPS-1] = coef_last_r;
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake: each stage takes a word when it is empty or drains
  // ---------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic f1, f2, f3, f4, f_out;
  logic accept;

  assign f_out    = !out_valid_r || out_ready;
  assign f4       = !v4_r || f_out;
  assign f3       = !v3_r || f4;
  assign f2       = !v2_r || f3;
  assign f1       = !v1_r || f2;
  assign in_ready = f1;
  assign accept   = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Stage 0: position counters, row store read, output window decision
  // ---------------------------------------------------------------------------
  logic [CW-1:0]          col_count_r, col_count_nxt;
  logic [2:0]             row_count_r, row_count_nxt;
  logic [CW-1:0]          c0;
  logic [2:0]             row0;
  logic                   inr0;
  logic [c5rgb_pkg::SPAN_W-1:0] span;
  logic [SW-1:0]          lim;
  c5rgb_pkg::s1_tag_t     tag0;

  always_comb begin
    c0   = in_frame_start ? '0 : col_count_r;
    row0 = in_frame_start ? '0 : row_count_r;
    inr0 = c0 < CW'(MAX_ROW_BYTES);
    span = (c5rgb_pkg::SPAN_W'(out_width_r) << 1) + c5rgb_pkg::SPAN_W'(out_width_r);
    // first column past the output span
    lim  = SW'(span) + SW'(c5rgb_pkg::FIRST_COL);

    tag0.in_range = inr0;
    tag0.emit     = (row0 == 3'(c5rgb_pkg::STORE_ROWS))
                    && (SW'(c0) >= SW'(c5rgb_pkg::FIRST_COL))
                    && (SW'(c0) < lim);
    tag0.row_end  = (SW'(c0) == lim - SW'(1));

    // advance position after this word
    col_count_nxt = col_count_r;
    row_count_nxt = row_count_r;
    if (accept) begin
      if (in_row_end) begin
        col_count_nxt = '0;
        row_count_nxt = (row0 < 3'(c5rgb_pkg::STORE_ROWS)) ? row0 + 3'd1 : row0;
      end else begin
        col_count_nxt = inr0 ? c0 + CW'(1) : c0;
        row_count_nxt = row0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
    end else begin
      col_count_r <= col_count_nxt;
      row_count_r <= row_count_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: row store data back, shift the column down and write it back
  // ---------------------------------------------------------------------------
  logic [AW-1:0]          c1_r;
  logic [7:0]             byte1_r;
  c5rgb_pkg::s1_tag_t     tag1_r;
  logic                   fwd_r;
  logic [RW-1:0]          fwd_data_r;
  logic [RW-1:0]          ram_rdata;
  logic [RW-1:0]          word1;
  logic [RW-1:0]          wdata1;
  logic [7:0]             col1 [c5rgb_pkg::WIN_ROWS];
  logic                   s1_we;
  logic                   fwd_nxt;

  assign s1_we   = v1_r && f2 && tag1_r.in_range;
  // the word leaving stage 1 writes the column the new word reads
  assign fwd_nxt = accept && s1_we && inr0 && (c0[AW-1:0] == c1_r);
  assign word1   = fwd_r ? fwd_data_r : ram_rdata;

  always_comb begin
    for (int r = 0; r < c5rgb_pkg::STORE_ROWS; r++) begin
      col1[r] = tag1_r.in_range ? word1[8*r +: 8] : 8'd0;
    end
    col1[c5rgb_pkg::STORE_ROWS] = byte1_r;
    for (int r = 0; r < c5rgb_pkg::STORE_ROWS; r++) begin
      wdata1[8*r +: 8] = col1[r+1];
    end
  end

  c5rgb_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_ROW_BYTES)
  ) u_row_store (
    .clk   (clk),
    .we    (s1_we),
    .waddr (c1_r),
    .wdata (wdata1),
    .re    (accept && inr0),
    .raddr (c0[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      fwd_r <= 1'b0;
    end else if (f1) begin
      v1_r  <= accept;
      fwd_r <= fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      c1_r       <= c0[AW-1:0];
      byte1_r    <= in_pixel_byte;
      tag1_r     <= tag0;
      fwd_data_r <= wdata1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: window of five rows by thirteen bytes
  // ---------------------------------------------------------------------------
  logic [7:0] win_r [c5rgb_pkg::WIN_ROWS][c5rgb_pkg::WIN_COLS];
  logic       end2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (f2) begin
      v2_r <= v1_r && tag1_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r && f2) begin
      for (int r = 0; r < c5rgb_pkg::WIN_ROWS; r++) begin
        for (int j = 0; j < c5rgb_pkg::WIN_COLS - 1; j++) begin
          win_r[r][j] <= win_r[r][j+1];
        end
        win_r[r][c5rgb_pkg::WIN_COLS-1] <= col1[r];
      end
      end2_r <= tag1_r.row_end;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: products, low 16 bits kept
  // ---------------------------------------------------------------------------
  logic [15:0] prod_r   [c5rgb_pkg::TAPS];
  logic [15:0] prod_nxt [c5rgb_pkg::TAPS];
  logic        end3_r;

  always_comb begin
    for (int k = 0; k < c5rgb_pkg::TAPS; k++) begin
      prod_nxt[k] = 16'(16'(win_r[k / c5rgb_pkg::TAP_COLS]
                                 [c5rgb_pkg::TAP_STEP * (k % c5rgb_pkg::TAP_COLS)])
                        * coef[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (f3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r && f3) begin
      prod_r <= prod_nxt;
      end3_r <= end2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: one sum per tap row, modulo 2^16
  // ---------------------------------------------------------------------------
  logic [15:0] rsum_r   [c5rgb_pkg::WIN_ROWS];
  logic [15:0] rsum_nxt [c5rgb_pkg::WIN_ROWS];
  logic        end4_r;

  always_comb begin
    for (int r = 0; r < c5rgb_pkg::WIN_ROWS; r++) begin
      rsum_nxt[r] = '0;
      for (int j = 0; j < c5rgb_pkg::TAP_COLS; j++) begin
        rsum_nxt[r] = rsum_nxt[r] + prod_r[c5rgb_pkg::TAP_COLS * r + j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (f4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v3_r && f4) begin
      rsum_r <= rsum_nxt;
      end4_r <= end3_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: final sum, read as signed, clamp to 0..255
  // ---------------------------------------------------------------------------
  logic [15:0] total;
  logic [7:0]  clamp_val;
  logic [7:0]  out_byte_r;
  logic        out_row_end_r;

  always_comb begin
    total = '0;
    for (int r = 0; r < c5rgb_pkg::WIN_ROWS; r++) begin
      total = total + rsum_r[r];
    end
    if (total[15]) begin
      clamp_val = 8'd0;
    end else if (total > 16'(c5rgb_pkg::PIX_MAX)) begin
      clamp_val = 8'(c5rgb_pkg::PIX_MAX);
    end else begin
      clamp_val = total[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (f_out) begin
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v4_r && f_out) begin
      out_byte_r    <= clamp_val;
      out_row_end_r <= end4_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_row_end = out_row_end_r;

`ifndef ASSERT_OFF
  // column counter saturates at the row store length
  a_col_sat: assert property (@(posedge clk) disable iff (!rst_n)
    col_count_r <= CW'(MAX_ROW_BYTES))
    else $error("column counter past row store length");

  // completed row count saturates at the number of stored rows
  a_row_sat: assert property (@(posedge clk) disable iff (!rst_n)
    row_count_r <= 3'(c5rgb_pkg::STORE_ROWS))
    else $error("row counter past stored rows");

  // a forwarded column only ever belongs to a word in stage 1
  a_fwd_owner: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> v1_r)
    else $error("forward data without a word in stage 1");

  // a blocked sum stage keeps its word
  a_s4_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !f_out) |=> (v4_r && $stable(end4_r)))
    else $error("stage 4 word lost under stall");
`endif

endmodule

`default_nettype wire
